@@ rtl/alc_pkg.sv @@
// alc_pkg: shared types, register codes and fixed-point constants of the
// ambient light lux calculator. Depends on nothing; imported by every rtl file.
package alc_pkg;

    // configuration register indexes
    localparam logic CFG_SENSOR_READY  = 1'b0;
    localparam logic CFG_SAT_THRESHOLD = 1'b1;

    localparam logic [15:0] SAT_THRESHOLD_RESET = 16'hFFFF;
    localparam logic [7:0]  STATUS_VALID_MASK   = 8'h04;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // quotient bits of the ratio divider, one per pipeline step
    localparam int DIV_STEPS = 17;

    // region thresholds, Q16
    localparam logic [16:0] T1_Q16 = 17'd29491;
    localparam logic [16:0] T2_Q16 = 17'd41943;
    localparam logic [16:0] T3_Q16 = 17'd55706;

    localparam logic [25:0] LUX_MAX_Q8 = 26'h3FF_FFFF;

    typedef enum logic [1:0] {
        REGION_1,
        REGION_2,
        REGION_3,
        REGION_NONE
    } region_t;

    // one classified sample as it travels from front to back
    typedef struct packed {
        logic        ok;
        logic        sat;
        logic        live;
        logic [15:0] ch0;
        logic [15:0] ch1;
        logic [16:0] sum;
    } item_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

    // Q16 coefficients, rounded to nearest
    function automatic logic signed [19:0] coef_a(region_t r);
        logic signed [19:0] c;
        case (r)
            REGION_1: c = 20'sd116281;
            REGION_2: c = 20'sd280396;
            REGION_3: c = 20'sd38837;
            default:  c = 20'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [19:0] coef_b(region_t r);
        logic signed [19:0] c;
        case (r)
            REGION_1: c = 20'sd72476;
            REGION_2: c = -20'sd128110;
            REGION_3: c = 20'sd18186;
            default:  c = 20'sd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/alc_front.sv @@
// alc_front: configuration registers, intake of samples and classification
// (data ok, saturation, channel sum). Depends on alc_pkg.
module alc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         status_byte,
    input  logic [15:0]        ch0_count,
    input  logic [15:0]        ch1_count,
    input  alc_pkg::q_status_t q_status,
    output logic               push,
    output alc_pkg::item_t     item
);
    import alc_pkg::*;

    logic        sensor_ready_reg;
    logic [15:0] sat_thr_reg;
    logic        ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_ready_reg <= 1'b0;
            sat_thr_reg      <= SAT_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SENSOR_READY:  sensor_ready_reg <= cfg_wdata[0];
                CFG_SAT_THRESHOLD: sat_thr_reg      <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign busy = q_status.full;
    assign push = start && !q_status.full;

    assign ok = sensor_ready_reg && ((status_byte & STATUS_VALID_MASK) != 8'h00);

    always_comb
    begin
        item.ok   = ok;
        item.sat  = ok && ((ch0_count >= sat_thr_reg) || (ch1_count >= sat_thr_reg));
        item.ch0  = ch0_count;
        item.ch1  = ch1_count;
        item.sum  = {1'b0, ch0_count} + {1'b0, ch1_count};
        item.live = ok && (item.sum != 17'd0);
    end

endmodule

@@ rtl/alc_queue.sv @@
// alc_queue: short queue of classified samples between front and back; the
// back always drains it. Depends on alc_pkg.
module alc_queue #(
    parameter int DEPTH = alc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  alc_pkg::item_t     item_in,
    output alc_pkg::q_status_t q_status,
    output logic               pop,
    output alc_pkg::item_t     item_out
);
    import alc_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == IDX_W'(DEPTH - 1))
            r = '0;
        else
            r = idx + IDX_W'(1);
        return r;
    endfunction

    assign pop               = (count_reg != '0);
    assign q_status.nonempty = pop;
    assign q_status.full     = (count_reg == CNT_W'(DEPTH));
    assign item_out          = mem_reg[rd_idx_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (!push && pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_idx_reg <= wrap_inc(wr_idx_reg);
            if (pop)
                rd_idx_reg <= wrap_inc(rd_idx_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_idx_reg] <= item_in;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into full queue");

endmodule

@@ rtl/alc_back.sv @@
// alc_back: pipelined ratio divider, region selection and lux arithmetic.
// Never stalls; one sample per cycle. Depends on alc_pkg.
module alc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    input  alc_pkg::item_t in_item,
    output logic           done,
    output logic           data_ok,
    output logic [16:0]    ratio_q16,
    output logic [25:0]    lux_q8,
    output logic           saturated
);
    import alc_pkg::*;

    typedef struct packed {
        logic        ok;
        logic        sat;
        logic        live;
        logic [15:0] ch0;
        logic [15:0] ch1;
        logic [16:0] sum;
        logic [16:0] rem;
        logic [16:0] quo;
    } div_t;

    // one restoring step: shift in a dividend bit, compare, subtract
    function automatic div_t div_step(div_t s, logic in_bit);
        div_t        r;
        logic [17:0] trial;
        logic [17:0] diff;
        r     = s;
        trial = {s.rem, in_bit};
        diff  = trial - {1'b0, s.sum};
        if (trial >= {1'b0, s.sum})
        begin
            r.rem = diff[16:0];
            r.quo = {s.quo[15:0], 1'b1};
        end
        else
        begin
            r.rem = trial[16:0];
            r.quo = {s.quo[15:0], 1'b0};
        end
        return r;
    endfunction

    // quotient and remainder tell exactly whether ratio <= t
    function automatic logic ratio_le(logic [16:0] q, logic [16:0] rem, logic [16:0] t);
        return (q < t) || ((q == t) && (rem == 17'd0));
    endfunction

    logic [DIV_STEPS:0] div_vld_reg;
    div_t               div_pay_reg  [DIV_STEPS+1];
    div_t               div_pay_next [DIV_STEPS];

    // region stage
    logic        reg_vld_reg;
    logic        reg_ok_reg;
    logic        reg_sat_reg;
    logic [16:0] reg_ratio_reg;
    region_t     reg_region_reg;
    logic [15:0] reg_ch0_reg;
    logic [15:0] reg_ch1_reg;
    region_t     region_next;

    // multiply stage
    logic               mul_vld_reg;
    logic               mul_ok_reg;
    logic               mul_sat_reg;
    logic [16:0]        mul_ratio_reg;
    logic               mul_zero_reg;
    logic signed [36:0] prod_a_reg;
    logic signed [36:0] prod_b_reg;

    // output stage
    logic               done_reg;
    logic               data_ok_reg;
    logic [16:0]        ratio_reg;
    logic [25:0]        lux_reg;
    logic               saturated_reg;
    logic signed [37:0] acc;
    logic [29:0]        acc_q8;
    logic [25:0]        lux_next;

    // dividend is ch1 * 65536; its bits above 16 seed the remainder
    always_ff @(posedge clk)
    begin
        div_pay_reg[0].ok   <= in_item.ok;
        div_pay_reg[0].sat  <= in_item.sat;
        div_pay_reg[0].live <= in_item.live;
        div_pay_reg[0].ch0  <= in_item.ch0;
        div_pay_reg[0].ch1  <= in_item.ch1;
        div_pay_reg[0].sum  <= in_item.sum;
        div_pay_reg[0].rem  <= {2'b00, in_item.ch1[15:1]};
        div_pay_reg[0].quo  <= 17'd0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        always_comb
        begin
            div_pay_next[k] = div_step(div_pay_reg[k],
                                       (k == 0) ? div_pay_reg[k].ch1[0] : 1'b0);
        end

        always_ff @(posedge clk)
        begin
            div_pay_reg[k+1] <= div_pay_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
            reg_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            div_vld_reg <= {div_vld_reg[DIV_STEPS-1:0], in_vld};
            reg_vld_reg <= div_vld_reg[DIV_STEPS];
            mul_vld_reg <= reg_vld_reg;
            done_reg    <= mul_vld_reg;
        end
    end

    always_comb
    begin
        region_next = REGION_NONE;
        if (div_pay_reg[DIV_STEPS].live)
        begin
            if (ratio_le(div_pay_reg[DIV_STEPS].quo, div_pay_reg[DIV_STEPS].rem, T1_Q16))
                region_next = REGION_1;
            else if (ratio_le(div_pay_reg[DIV_STEPS].quo, div_pay_reg[DIV_STEPS].rem,
                              T2_Q16))
                region_next = REGION_2;
            else if (ratio_le(div_pay_reg[DIV_STEPS].quo, div_pay_reg[DIV_STEPS].rem,
                              T3_Q16))
                region_next = REGION_3;
        end
    end

    always_ff @(posedge clk)
    begin
        reg_ok_reg     <= div_pay_reg[DIV_STEPS].ok;
        reg_sat_reg    <= div_pay_reg[DIV_STEPS].sat;
        reg_ratio_reg  <= div_pay_reg[DIV_STEPS].live ? div_pay_reg[DIV_STEPS].quo : 17'd0;
        reg_region_reg <= region_next;
        reg_ch0_reg    <= div_pay_reg[DIV_STEPS].ch0;
        reg_ch1_reg    <= div_pay_reg[DIV_STEPS].ch1;

        mul_ok_reg    <= reg_ok_reg;
        mul_sat_reg   <= reg_sat_reg;
        mul_ratio_reg <= reg_ratio_reg;
        mul_zero_reg  <= (reg_region_reg == REGION_NONE);
        prod_a_reg    <= 37'(coef_a(reg_region_reg)) * 37'($signed({1'b0, reg_ch0_reg}));
        prod_b_reg    <= 37'(coef_b(reg_region_reg)) * 37'($signed({1'b0, reg_ch1_reg}));
    end

    // clamp negatives, drop 8 fraction bits, saturate to 26 bits
    always_comb
    begin
        acc    = 38'(prod_a_reg) + 38'(prod_b_reg);
        acc_q8 = acc[37:8];
        if (mul_zero_reg || acc[37])
            lux_next = 26'd0;
        else if (acc_q8 > 30'(LUX_MAX_Q8))
            lux_next = LUX_MAX_Q8;
        else
            lux_next = acc_q8[25:0];
    end

    always_ff @(posedge clk)
    begin
        data_ok_reg   <= mul_ok_reg;
        ratio_reg     <= mul_ratio_reg;
        lux_reg       <= lux_next;
        saturated_reg <= mul_sat_reg;
    end

    assign done      = done_reg;
    assign data_ok   = data_ok_reg;
    assign ratio_q16 = ratio_reg;
    assign lux_q8    = lux_reg;
    assign saturated = saturated_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        div_vld_reg[0] |-> ##(DIV_STEPS + 3) done_reg)
        else $error("sample lost in back pipeline");

    a_not_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !data_ok_reg) |->
            (ratio_reg == 17'd0 && lux_reg == 26'd0 && !saturated_reg))
        else $error("result fields set without valid data");

endmodule

@@ rtl/ambient_light_lux_calculator.sv @@
// ambient_light_lux_calculator: top level; front intake, queue and
// divider/lux back end. Depends on alc_pkg, alc_front, alc_queue, alc_back.
// Pipeline: done rises after a sample accepted into the queue passes the divider
//   input register, 17 divider steps, region, multiply and output registers.
// Throughput: one sample per cycle while busy is low; the 17-step divider pipeline sets depth.
// The receiver cannot stall, so busy stays low in normal operation.
// Reset: rst_n asynchronous active low, clears pipeline valids, queue,
//   sensor_ready to 0 and saturation_threshold to 65535.
module ambient_light_lux_calculator #(
    parameter int QUEUE_DEPTH = alc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  status_byte,
    input  logic [15:0] ch0_count,
    input  logic [15:0] ch1_count,
    // result side, one beat per strobe
    output logic        done,
    output logic        data_ok,
    output logic [16:0] ratio_q16,
    output logic [25:0] lux_q8,
    output logic        saturated
);
    import alc_pkg::*;

    // classified beat from the front into the queue
    logic      push;
    item_t     front_item;
    // queue status back to the front (full holds off start)
    q_status_t q_status;
    // queue head into the back end, drained every cycle it holds a beat
    logic      pop;
    item_t     head_item;

    // front: config registers, data ok, saturation, channel sum
    alc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .status_byte (status_byte),
        .ch0_count   (ch0_count),
        .ch1_count   (ch1_count),
        .q_status    (q_status),
        .push        (push),
        .item        (front_item)
    );

    // queue decoupling intake from the arithmetic pipeline
    alc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .q_status (q_status),
        .pop      (pop),
        .item_out (head_item)
    );

    // back: ratio divider, region pick, lux multiply-add, output register
    alc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (pop),
        .in_item   (head_item),
        .done      (done),
        .data_ok   (data_ok),
        .ratio_q16 (ratio_q16),
        .lux_q8    (lux_q8),
        .saturated (saturated)
    );

endmodule

@@ verif/tb_ambient_light_lux_calculator.sv @@
// tb_ambient_light_lux_calculator: self-checking bench for the lux calculator,
// with a scoreboard class that predicts each result beat and checks it in order.
// Depends on alc_pkg and rtl/ambient_light_lux_calculator.sv.
module tb_ambient_light_lux_calculator;
    import alc_pkg::*;

    // one result beat as the block reports it
    typedef struct packed {
        logic        ok;
        logic [16:0] ratio;
        logic [25:0] lux;
        logic        sat;
    } lux_beat_t;

    // expected lux beats, predicted from the register copy at accept time
    class lux_scoreboard;
        logic        ready_reg;
        logic [15:0] sat_thr_reg;
        lux_beat_t   expected_q[$];
        int          error_count;

        function new();
            ready_reg   = 1'b0;
            sat_thr_reg = SAT_THRESHOLD_RESET;
            error_count = 0;
        endfunction

        function void apply_write(logic idx, logic [15:0] data);
            if (idx == CFG_SENSOR_READY)
                ready_reg = data[0];
            else if (idx == CFG_SAT_THRESHOLD)
                sat_thr_reg = data;
        endfunction

        function lux_beat_t predict_lux(logic [7:0] st, logic [15:0] c0, logic [15:0] c1);
            lux_beat_t beat;
            region_t   rgn;
            longint    sum;
            longint    num;
            longint    acc;
            longint    gain_a;
            longint    gain_b;
            beat = '0;
            beat.ok = ready_reg && ((st & STATUS_VALID_MASK) != 8'd0);
            if (!beat.ok)
                return beat;
            beat.sat = (c0 >= sat_thr_reg) || (c1 >= sat_thr_reg);
            sum = longint'(c0) + longint'(c1);
            if (sum == 0)
                return beat;
            num = longint'(c1) << 16;
            beat.ratio = 17'(num / sum);
            // thresholds compared exactly, no division involved
            if (num <= longint'(T1_Q16) * sum)
                rgn = REGION_1;
            else if (num <= longint'(T2_Q16) * sum)
                rgn = REGION_2;
            else if (num <= longint'(T3_Q16) * sum)
                rgn = REGION_3;
            else
                rgn = REGION_NONE;
            // Q16 region gains
            case (rgn)
                REGION_1:
                begin
                    gain_a = 116281;
                    gain_b = 72476;
                end
                REGION_2:
                begin
                    gain_a = 280396;
                    gain_b = -128110;
                end
                REGION_3:
                begin
                    gain_a = 38837;
                    gain_b = 18186;
                end
                default:
                begin
                    gain_a = 0;
                    gain_b = 0;
                end
            endcase
            acc = gain_a * longint'(c0) + gain_b * longint'(c1);
            if (acc < 0)
                acc = 0;
            acc = acc >>> 8;
            if (acc > longint'(LUX_MAX_Q8))
                acc = longint'(LUX_MAX_Q8);
            beat.lux = 26'(acc);
            return beat;
        endfunction

        function void note_sample(logic [7:0] st, logic [15:0] c0, logic [15:0] c1);
            expected_q.push_back(predict_lux(st, c0, c1));
        endfunction

        function void check_beat(lux_beat_t got);
            lux_beat_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result beat ok=%0b ratio=%0d lux=%0d sat=%0b",
                         $time, got.ok, got.ratio, got.lux, got.sat);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.ok !== want.ok)
            begin
                $display("%0t: data_ok expected %0b actual %0b", $time, want.ok, got.ok);
                error_count++;
            end
            if (got.ratio !== want.ratio)
            begin
                $display("%0t: ratio_q16 expected %0d actual %0d", $time, want.ratio, got.ratio);
                error_count++;
            end
            if (got.lux !== want.lux)
            begin
                $display("%0t: lux_q8 expected %0d actual %0d", $time, want.lux, got.lux);
                error_count++;
            end
            if (got.sat !== want.sat)
            begin
                $display("%0t: saturated expected %0b actual %0b", $time, want.sat, got.sat);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        start;
    logic        busy;
    logic [7:0]  status_byte;
    logic [15:0] ch0_count;
    logic [15:0] ch1_count;
    logic        done;
    logic        data_ok;
    logic [16:0] ratio_q16;
    logic [25:0] lux_q8;
    logic        saturated;

    lux_scoreboard sb;
    // high while the sender runs back to back with no gaps
    bit            no_idle;
    lux_beat_t     seen_beat;

    ambient_light_lux_calculator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .status_byte (status_byte),
        .ch0_count   (ch0_count),
        .ch1_count   (ch1_count),
        .done        (done),
        .data_ok     (data_ok),
        .ratio_q16   (ratio_q16),
        .lux_q8      (lux_q8),
        .saturated   (saturated)
    );

    always #10 clk = ~clk;

    // result beats cannot be held off, so every strobe is checked at its edge
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            seen_beat.ok    = data_ok;
            seen_beat.ratio = ratio_q16;
            seen_beat.lux   = lux_q8;
            seen_beat.sat   = saturated;
            sb.check_beat(seen_beat);
        end
    end

    // register write: the enable is raised with index and data, then dropped again before the task returns
    task automatic cfg_write(input logic idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.apply_write(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // one command beat: optional gap with junk on the fields, then hold until accepted
    task automatic send_sample(input logic [7:0] st, input logic [15:0] c0,
                               input logic [15:0] c1);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start       <= 1'b0;
            status_byte <= 8'($urandom);
            ch0_count   <= 16'($urandom);
            ch1_count   <= 16'($urandom);
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        status_byte <= st;
        ch0_count   <= c0;
        ch1_count   <= c1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_sample(st, c0, c1);
    endtask

    // sender pauses until the pipeline has handed back every beat
    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // full-scale ends plus a random value now and then
    function automatic int corner_count();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return 65534;
            3:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic send_random_sample();
        logic [7:0] st;
        int         sum;
        int         thr;
        int         c0;
        int         c1;
        // mostly samples flagged as new data, the rest any status
        if ($urandom_range(0, 4) != 0)
            st = 8'($urandom) | STATUS_VALID_MASK;
        else
            st = 8'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                c0 = $urandom_range(0, 65535);
                c1 = $urandom_range(0, 65535);
            end
            4, 5:
            begin
                // ratio right at a region boundary, one count either side
                sum = $urandom_range(1, 65535);
                case ($urandom_range(0, 2))
                    0:       thr = T1_Q16;
                    1:       thr = T2_Q16;
                    default: thr = T3_Q16;
                endcase
                c1 = int'((longint'(sum) * thr) >>> 16) + int'($urandom_range(0, 2)) - 1;
                if (c1 < 0)
                    c1 = 0;
                if (c1 > sum)
                    c1 = sum;
                c0 = sum - c1;
            end
            6:
            begin
                c0 = $urandom_range(0, 255);
                c1 = $urandom_range(0, 255);
            end
            7:
            begin
                c0 = corner_count();
                c1 = corner_count();
            end
            8:
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    c0 = 0;
                    c1 = $urandom_range(0, 65535);
                end
                else
                begin
                    c0 = $urandom_range(0, 65535);
                    c1 = 0;
                end
            end
            default:
            begin
                c0 = $urandom_range(0, 255);
                c1 = $urandom_range(0, 65535);
            end
        endcase
        send_sample(st, 16'(c0), 16'(c1));
    endtask

    initial
    begin
        int blk;
        int n;
        int block_len;
        sb          = new();
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_SENSOR_READY;
        cfg_wdata   = 16'd0;
        start       = 1'b0;
        status_byte = 8'd0;
        ch0_count   = 16'd0;
        ch1_count   = 16'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: not ready, so every beat reports no data
        send_sample(8'hFF, 16'd1000, 16'd200);
        send_sample(STATUS_VALID_MASK, 16'hFFFF, 16'hFFFF);
        wait_results();

        // ready, upper data bits must be ignored
        cfg_write(CFG_SENSOR_READY, 16'hABC1);
        send_sample(STATUS_VALID_MASK, 16'd0, 16'd0);          // both channels dark
        send_sample(STATUS_VALID_MASK, 16'd0, 16'd1);          // infrared only
        send_sample(8'hFF, 16'd0, 16'hFFFF);
        send_sample(STATUS_VALID_MASK, 16'hFFFF, 16'd0);
        send_sample(STATUS_VALID_MASK, 16'hFFFF, 16'hFFFF);    // saturated at reset threshold
        send_sample(8'hFB, 16'd5000, 16'd1000);                // valid bit clear
        send_sample(8'h00, 16'hFFFF, 16'hFFFF);
        // exact region boundaries with sum 65536, then one count over
        send_sample(STATUS_VALID_MASK, 16'd36045, 16'd29491);
        send_sample(STATUS_VALID_MASK, 16'd36044, 16'd29492);
        send_sample(STATUS_VALID_MASK, 16'd23593, 16'd41943);
        send_sample(STATUS_VALID_MASK, 16'd23592, 16'd41944);
        send_sample(STATUS_VALID_MASK, 16'd9830, 16'd55706);
        send_sample(STATUS_VALID_MASK, 16'd9829, 16'd55707);
        send_sample(8'hFF, 16'd65535, 16'd53618);              // top of first region
        send_sample(STATUS_VALID_MASK, 16'd65535, 16'd53619);  // bottom of second region
        wait_results();

        // threshold extremes
        cfg_write(CFG_SAT_THRESHOLD, 16'd0);
        send_sample(STATUS_VALID_MASK, 16'd0, 16'd0);
        send_sample(8'hFB, 16'd0, 16'd0);
        wait_results();
        cfg_write(CFG_SAT_THRESHOLD, 16'd1);
        send_sample(STATUS_VALID_MASK, 16'd0, 16'd0);
        send_sample(STATUS_VALID_MASK, 16'd1, 16'd0);
        send_sample(STATUS_VALID_MASK, 16'd0, 16'd1);
        wait_results();

        // random phases, one register setting each
        for (blk = 0; blk < 5; blk++)
        begin
            case (blk)
                0:
                begin
                    cfg_write(CFG_SENSOR_READY, {15'($urandom), 1'b1});
                    cfg_write(CFG_SAT_THRESHOLD, 16'hFFFF);
                end
                1:
                begin
                    cfg_write(CFG_SENSOR_READY, {15'($urandom), 1'b1});
                    cfg_write(CFG_SAT_THRESHOLD, 16'($urandom));
                end
                2:
                begin
                    cfg_write(CFG_SENSOR_READY, {15'($urandom), 1'b1});
                    cfg_write(CFG_SAT_THRESHOLD, 16'($urandom_range(0, 300)));
                end
                3:
                begin
                    cfg_write(CFG_SENSOR_READY, {15'($urandom), 1'b0});
                    cfg_write(CFG_SAT_THRESHOLD, 16'($urandom));
                end
                default:
                begin
                    cfg_write(CFG_SENSOR_READY, {15'($urandom), 1'b1});
                    cfg_write(CFG_SAT_THRESHOLD, 16'd0);
                end
            endcase
            block_len = (blk == 3) ? 60 : 145;
            for (n = 0; n < block_len; n++)
            begin
                // redraw the gap mode now and then so back-to-back stretches occur
                if (n % 20 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                // full drain mid-phase
                if (blk == 2 && n == 70)
                    wait_results();
                send_random_sample();
            end
            wait_results();
        end

        // tail: any stray beat shows up as unexpected
        repeat (30) @(posedge clk);
        if (sb.error_count == 0)
            $display("** ambient_light_lux_calculator: PASSED **");
        else
            $display("** ambient_light_lux_calculator: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("** ambient_light_lux_calculator: FAILED **");
        $finish;
    end

endmodule
